// ----- sv/sdt_pkg.sv -----
// Shared types and constants of the SDT section parser.
`timescale 1ns / 1ps

package sdt_pkg;

    // Record kinds, carried on the master tuser
    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_SERVICE = 3'd1;
    localparam logic [2:0] KIND_PROV    = 3'd2;
    localparam logic [2:0] KIND_SNAME   = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    localparam logic [7:0] TAG_SERVICE_DESC = 8'h48;
    localparam int         LOOP_START       = 11;
    localparam int         CRC_BYTES        = 4;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [15:0] {
        PH_HDR     = 16'b0000_0000_0000_0001,
        PH_SVC0    = 16'b0000_0000_0000_0010,
        PH_SVC1    = 16'b0000_0000_0000_0100,
        PH_SVC2    = 16'b0000_0000_0000_1000,
        PH_SVC3    = 16'b0000_0000_0001_0000,
        PH_SVC4    = 16'b0000_0000_0010_0000,
        PH_DTAG    = 16'b0000_0000_0100_0000,
        PH_DLEN_O  = 16'b0000_0000_1000_0000,
        PH_DLEN_SD = 16'b0000_0001_0000_0000,
        PH_SKIP    = 16'b0000_0010_0000_0000,
        PH_STYPE   = 16'b0000_0100_0000_0000,
        PH_PLEN    = 16'b0000_1000_0000_0000,
        PH_PNAME   = 16'b0001_0000_0000_0000,
        PH_SLEN    = 16'b0010_0000_0000_0000,
        PH_SNAME   = 16'b0100_0000_0000_0000,
        PH_IDLE    = 16'b1000_0000_0000_0000
    } t_phase;

    typedef struct packed {
        logic [15:0] tsid;
        logic [15:0] onid;
        logic [4:0]  ver;
        logic [7:0]  sn;
        logic [7:0]  lsn;
        logic        cn;
    } t_hdr;

    typedef struct packed {
        logic [15:0] id;
        logic        eit_s;
        logic        eit_pf;
        logic [2:0]  running;
        logic        ca;
    } t_svc;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] ident;
        logic [15:0] network_id;
        logic [4:0]  version;
        logic [7:0]  section_index;
        logic [7:0]  last_section_index;
        logic        current_next;
        logic        eit_schedule;
        logic        eit_present_following;
        logic [2:0]  running_state;
        logic        free_ca;
        logic [7:0]  payload_byte;
    } t_rec;

    function automatic t_rec f_rec(input logic [2:0] kind, input logic [15:0] ident,
                                   input t_hdr hdr, input t_svc svc, input logic svc_en,
                                   input logic [7:0] payload);
        t_rec r;
        r.kind                  = kind;
        r.ident                 = ident;
        r.network_id            = hdr.onid;
        r.version               = hdr.ver;
        r.section_index         = hdr.sn;
        r.last_section_index    = hdr.lsn;
        r.current_next          = hdr.cn;
        r.eit_schedule          = svc_en & svc.eit_s;
        r.eit_present_following = svc_en & svc.eit_pf;
        r.running_state         = svc_en ? svc.running : 3'd0;
        r.free_ca               = svc_en & svc.ca;
        r.payload_byte          = payload;
        return r;
    endfunction

endpackage

// ----- sv/dvb_sdt_section_parser.sv -----
// Top level of the DVB SDT section parser.
`timescale 1ns / 1ps

// Parses one SDT section per run of bytes, one byte per item on the slave
// stream, tuser marking the first byte of each section. Every byte is decoded
// in the cycle it is accepted and its records go into a four-entry output queue,
// so a byte is taken every cycle while the queue has room for two records. A
// byte that causes two records (byte 9 of a very short section, or a last name
// byte that closes a service) keeps the master side busy with both records; the
// sustained input rate is one byte per cycle as long as results drain at one
// per cycle. Record order per byte: header, name byte, service, section end.
module dvb_sdt_section_parser
    import sdt_pkg::*;
#(
    parameter int MAX_SECTION_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [0:0]  s_axis_tuser,   // first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ident, network_id, version, section_index, last_section_index,
    // current_next, eit_schedule, eit_present_following, running_state,
    // free_ca, payload_byte, 4 zero bits
    output logic [71:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser    // kind
);

    localparam int         PW      = $clog2(MAX_SECTION_BYTES);
    localparam logic [11:0] MAX_LEN = 12'(MAX_SECTION_BYTES - 3);

    logic [PW-1:0] r_pos, n_pos;
    logic [11:0]   r_slr, n_slr;
    t_hdr          r_hdr, n_hdr;
    t_svc          r_svc, n_svc;
    logic [11:0]   r_lr, n_lr;
    t_phase        r_phase, n_phase;
    logic [7:0]    r_dr, n_dr;
    logic [7:0]    r_nr, n_nr;
    logic [7:0]    r_stype, n_stype;

    logic          accept;
    logic [7:0]    b;
    logic [PW-1:0] p;
    logic [11:0]   slr_raw;
    logic [7:0]    dr_dec;
    logic [7:0]    nr_dec;
    logic          emit_hdr, emit_name, emit_svc, emit_end;
    logic [2:0]    name_kind;
    t_phase        dnext;

    logic [1:0]    push_cnt;
    t_rec          rec0, rec1, out_rec;
    t_rec          hdr_rec, name_rec, svc_rec, end_rec;
    logic          room;

    assign accept        = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = room;
    assign b             = s_axis_tdata;
    assign p             = r_pos + PW'(1);
    assign slr_raw       = {r_slr[11:8], b};
    assign dr_dec        = r_dr - 8'd1;
    assign nr_dec        = r_nr - 8'd1;

    always_comb begin
        n_pos     = r_pos;
        n_slr     = r_slr;
        n_hdr     = r_hdr;
        n_svc     = r_svc;
        n_lr      = r_lr;
        n_phase   = r_phase;
        n_dr      = r_dr;
        n_nr      = r_nr;
        n_stype   = r_stype;
        emit_hdr  = 1'b0;
        emit_name = 1'b0;
        emit_svc  = 1'b0;
        emit_end  = 1'b0;
        name_kind = KIND_PROV;
        dnext     = r_phase;
        if (accept) begin
            if (s_axis_tuser[0]) begin
                n_pos   = '0;
                n_slr   = '0;
                n_hdr   = '0;
                n_svc   = '0;
                n_lr    = '0;
                n_dr    = '0;
                n_nr    = '0;
                n_stype = '0;
                n_phase = PH_HDR;
            end else if (r_phase != PH_IDLE) begin
                n_pos = p;
                case (p)
                    PW'(1): n_slr = {b[3:0], 8'h00};
                    PW'(2): n_slr = (slr_raw > MAX_LEN) ? MAX_LEN : slr_raw;
                    PW'(3): n_hdr.tsid[15:8] = b;
                    PW'(4): n_hdr.tsid[7:0] = b;
                    PW'(5): begin
                        n_hdr.ver = b[5:1];
                        n_hdr.cn  = b[0];
                    end
                    PW'(6): n_hdr.sn = b;
                    PW'(7): n_hdr.lsn = b;
                    PW'(8): n_hdr.onid[15:8] = b;
                    PW'(9): begin
                        n_hdr.onid[7:0] = b;
                        emit_hdr        = 1'b1;
                    end
                    PW'(10): n_phase = PH_SVC0;
                    default: begin
                        if (p >= PW'(LOOP_START) &&
                            13'(p) + 13'(CRC_BYTES - 3) < {1'b0, r_slr}) begin
                            case (r_phase)
                                PH_SVC0: begin
                                    n_svc.id[15:8] = b;
                                    n_phase        = PH_SVC1;
                                end
                                PH_SVC1: begin
                                    n_svc.id[7:0] = b;
                                    n_phase       = PH_SVC2;
                                end
                                PH_SVC2: begin
                                    n_svc.eit_s  = b[1];
                                    n_svc.eit_pf = b[0];
                                    n_phase      = PH_SVC3;
                                end
                                PH_SVC3: begin
                                    n_svc.running = b[7:5];
                                    n_svc.ca      = b[4];
                                    n_lr          = {b[3:0], 8'h00};
                                    n_phase       = PH_SVC4;
                                end
                                PH_SVC4: begin
                                    n_lr    = {r_lr[11:8], b};
                                    n_stype = 8'h00;
                                    if (n_lr == 12'd0) begin
                                        emit_svc = 1'b1;
                                        n_phase  = PH_SVC0;
                                    end else begin
                                        n_phase = PH_DTAG;
                                    end
                                end
                                PH_DTAG, PH_DLEN_O, PH_DLEN_SD, PH_SKIP, PH_STYPE,
                                PH_PLEN, PH_PNAME, PH_SLEN, PH_SNAME: begin
                                    n_lr = r_lr - 12'd1;
                                    if (r_phase == PH_DTAG) begin
                                        dnext = (b == TAG_SERVICE_DESC) ? PH_DLEN_SD
                                                                        : PH_DLEN_O;
                                    end else if (r_phase == PH_DLEN_O ||
                                                 r_phase == PH_DLEN_SD) begin
                                        n_dr = b;
                                        if (b == 8'h00) begin
                                            dnext = PH_DTAG;
                                        end else if (r_phase == PH_DLEN_SD) begin
                                            dnext = PH_STYPE;
                                        end else begin
                                            dnext = PH_SKIP;
                                        end
                                    end else begin
                                        n_dr = dr_dec;
                                        if (r_phase == PH_STYPE) begin
                                            n_stype = b;
                                            dnext   = PH_PLEN;
                                        end else if (r_phase == PH_PLEN) begin
                                            n_nr  = b;
                                            dnext = (b != 8'h00) ? PH_PNAME : PH_SLEN;
                                        end else if (r_phase == PH_PNAME) begin
                                            emit_name = 1'b1;
                                            name_kind = KIND_PROV;
                                            n_nr      = nr_dec;
                                            dnext = (nr_dec != 8'h00) ? PH_PNAME : PH_SLEN;
                                        end else if (r_phase == PH_SLEN) begin
                                            n_nr  = b;
                                            dnext = (b != 8'h00) ? PH_SNAME : PH_SKIP;
                                        end else if (r_phase == PH_SNAME) begin
                                            emit_name = 1'b1;
                                            name_kind = KIND_SNAME;
                                            n_nr      = nr_dec;
                                            dnext = (nr_dec != 8'h00) ? PH_SNAME : PH_SKIP;
                                        end
                                        // descriptor exhausted: next byte is a tag
                                        if (dr_dec == 8'h00) begin
                                            dnext = PH_DTAG;
                                        end
                                    end
                                    n_phase = dnext;
                                    if (n_lr == 12'd0) begin
                                        emit_svc = 1'b1;
                                        n_phase  = PH_SVC0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                endcase
                if (p >= PW'(2) && 13'(p) == {1'b0, n_slr} + 13'd2) begin
                    emit_end = 1'b1;
                    n_phase  = PH_IDLE;
                end
            end
        end
    end

    assign hdr_rec  = f_rec(KIND_HEADER, n_hdr.tsid, n_hdr, n_svc, 1'b0, 8'h00);
    assign name_rec = f_rec(name_kind, 16'h0000, n_hdr, n_svc, 1'b0, b);
    assign svc_rec  = f_rec(KIND_SERVICE, n_svc.id, n_hdr, n_svc, 1'b1, n_stype);
    assign end_rec  = f_rec(KIND_END, n_hdr.tsid, n_hdr, n_svc, 1'b0, 8'h00);

    // pack this byte's records in order; header and name never share a byte
    always_comb begin
        push_cnt = 2'd0;
        rec0     = hdr_rec;
        rec1     = end_rec;
        if (emit_hdr) begin
            rec0     = hdr_rec;
            push_cnt = 2'd1;
        end
        if (emit_name) begin
            rec0     = name_rec;
            push_cnt = 2'd1;
        end
        if (emit_svc) begin
            if (push_cnt == 2'd0) begin
                rec0 = svc_rec;
            end else begin
                rec1 = svc_rec;
            end
            push_cnt = push_cnt + 2'd1;
        end
        if (emit_end) begin
            if (push_cnt == 2'd0) begin
                rec0 = end_rec;
            end else begin
                rec1 = end_rec;
            end
            push_cnt = push_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_slr   <= '0;
            r_hdr   <= '0;
            r_svc   <= '0;
            r_lr    <= '0;
            r_phase <= PH_IDLE;
            r_dr    <= '0;
            r_nr    <= '0;
            r_stype <= '0;
        end else begin
            r_pos   <= n_pos;
            r_slr   <= n_slr;
            r_hdr   <= n_hdr;
            r_svc   <= n_svc;
            r_lr    <= n_lr;
            r_phase <= n_phase;
            r_dr    <= n_dr;
            r_nr    <= n_nr;
            r_stype <= n_stype;
        end
    end

    sdt_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_rec0     (rec0),
        .i_rec1     (rec1),
        .o_room     (room),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_rec      (out_rec)
    );

    assign m_axis_tuser = out_rec.kind;
    assign m_axis_tdata = {4'b0000,
                           out_rec.payload_byte,
                           out_rec.free_ca,
                           out_rec.running_state,
                           out_rec.eit_present_following,
                           out_rec.eit_schedule,
                           out_rec.current_next,
                           out_rec.last_section_index,
                           out_rec.section_index,
                           out_rec.version,
                           out_rec.network_id,
                           out_rec.ident};

endmodule

// ----- sv/sdt_out_fifo.sv -----
// Result queue of the SDT parser: takes up to two records a cycle, gives one while i_ready is high.
`timescale 1ns / 1ps

module sdt_out_fifo
    import sdt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_rec       i_rec0,
    input  t_rec       i_rec1,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_rec       o_rec
);

    t_rec                 r_slot [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr;
    logic [OUT_PTR_W-1:0] r_rd;
    logic [OUT_CNT_W-1:0] r_cnt;
    logic [OUT_PTR_W-1:0] wr1;
    logic                 pop;

    assign wr1     = r_wr + OUT_PTR_W'(1);
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid & i_ready;
    assign o_rec   = r_slot[r_rd];
    // leave space for the two records one byte may cause
    assign o_room  = (r_cnt <= OUT_CNT_W'(OUT_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + OUT_PTR_W'(i_push_cnt);
            r_rd  <= r_rd + OUT_PTR_W'(pop);
            r_cnt <= r_cnt + OUT_CNT_W'(i_push_cnt) - OUT_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_slot[r_wr] <= i_rec0;
        end
        if (i_push_cnt == 2'd2) begin
            r_slot[wr1] <= i_rec1;
        end
    end

endmodule
